[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL modules.
// Each macro expects signals named clk and rst in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication: when pre holds, post holds in the same cycle.
`define ASSERT_IMPLIES(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication: when pre holds, post holds in the following cycle.
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/uqd_pkg.sv]
// ----------------------------------------------------------------------------
// uqd_pkg
// Types, character codes and helpers for the URL query decoder.
// ----------------------------------------------------------------------------
package uqd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       query_done;
    logic [1:0] fault;
  } out_t;

  typedef enum logic [1:0] {
    MODE_NAME      = 2'd0,
    MODE_NAME_ESC  = 2'd1,
    MODE_VALUE     = 2'd2,
    MODE_VALUE_ESC = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [3:0] high_nibble;
    logic       nibble_held;
    logic       name_seen;
    logic       failed;
  } state_t;

  localparam state_t STATE_RESET = '{
    mode:        MODE_NAME,
    high_nibble: 4'd0,
    nibble_held: 1'b0,
    name_seen:   1'b0,
    failed:      1'b0
  };

  // Result kinds
  localparam logic [2:0] KIND_NOTHING     = 3'd0;
  localparam logic [2:0] KIND_NAME_BYTE   = 3'd1;
  localparam logic [2:0] KIND_VALUE_BYTE  = 3'd2;
  localparam logic [2:0] KIND_VALUE_OPEN  = 3'd3;
  localparam logic [2:0] KIND_PARAM_CLOSE = 3'd4;

  // Fault codes
  localparam logic [1:0] FAULT_NONE       = 2'd0;
  localparam logic [1:0] FAULT_EMPTY_NAME = 2'd1;
  localparam logic [1:0] FAULT_DISALLOWED = 2'd2;
  localparam logic [1:0] FAULT_BAD_ESCAPE = 2'd3;

  // Characters
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_Z  = 8'h7a;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;

  function automatic logic plain_char(input logic [7:0] c);
    logic digit, lower, upper, mark;
    digit = (c >= CH_0) && (c <= CH_9);
    lower = (c >= CH_LOW_A) && (c <= CH_LOW_Z);
    upper = (c >= CH_UP_A) && (c <= CH_UP_Z);
    mark  = (c == CH_STAR) || (c == CH_DASH) || (c == CH_DOT) ||
            (c == CH_UNDER) || (c == CH_TILDE);
    return digit || lower || upper || mark;
  endfunction

  // Bit 4 set marks a non-hex character.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if ((c >= CH_0) && (c <= CH_9)) begin
      d = c - CH_0;
    end else if ((c >= CH_LOW_A) && (c <= CH_LOW_F)) begin
      d = c - CH_LOW_A + 8'd10;
    end else if ((c >= CH_UP_A) && (c <= CH_UP_F)) begin
      d = c - CH_UP_A + 8'd10;
    end else begin
      d = 8'd16;
    end
    return d[4:0];
  endfunction

endpackage

[rtl/uqd_step.sv]
// ----------------------------------------------------------------------------
// uqd_step
// Decode of one query byte against the parser state: result and next state.
// ----------------------------------------------------------------------------
module uqd_step (
  input  uqd_pkg::state_t st,
  input  uqd_pkg::in_t    req,
  output uqd_pkg::state_t st_next,
  output uqd_pkg::out_t   res
);

  logic [7:0] c;
  logic       last;
  logic       in_name;
  logic       in_escape;
  logic [4:0] hv;
  logic       hex_ok;

  logic [1:0] evt_fault;
  logic [2:0] evt_kind;
  logic [7:0] evt_byte;
  logic       seen_upd;
  logic [1:0] fault_fin;

  assign c         = req.in_byte;
  assign last      = req.in_last;
  assign in_name   = (st.mode == uqd_pkg::MODE_NAME);
  assign in_escape = (st.mode == uqd_pkg::MODE_NAME_ESC) ||
                     (st.mode == uqd_pkg::MODE_VALUE_ESC);
  assign hv        = uqd_pkg::hex_val(c);
  assign hex_ok    = !hv[4];

  // Classify the byte ahead of the end-of-query check.
  always_comb begin
    evt_fault = uqd_pkg::FAULT_NONE;
    evt_kind  = uqd_pkg::KIND_NOTHING;
    evt_byte  = 8'd0;
    if (!in_escape) begin
      if (in_name && (c == uqd_pkg::CH_EQ)) begin
        if (!st.name_seen) evt_fault = uqd_pkg::FAULT_EMPTY_NAME;
        else evt_kind = uqd_pkg::KIND_VALUE_OPEN;
      end else if (c == uqd_pkg::CH_AMP) begin
        if (!st.name_seen) evt_fault = uqd_pkg::FAULT_EMPTY_NAME;
        else evt_kind = uqd_pkg::KIND_PARAM_CLOSE;
      end else if (uqd_pkg::plain_char(c) || (c == uqd_pkg::CH_PLUS)) begin
        evt_byte = (c == uqd_pkg::CH_PLUS) ? uqd_pkg::CH_SPACE : c;
        evt_kind = in_name ? uqd_pkg::KIND_NAME_BYTE : uqd_pkg::KIND_VALUE_BYTE;
      end else if (c != uqd_pkg::CH_PCT) begin
        evt_fault = uqd_pkg::FAULT_DISALLOWED;
      end
    end else begin
      if (!hex_ok) begin
        evt_fault = uqd_pkg::FAULT_BAD_ESCAPE;
      end else if (st.nibble_held) begin
        evt_byte = {st.high_nibble, hv[3:0]};
        evt_kind = (st.mode == uqd_pkg::MODE_NAME_ESC) ?
                   uqd_pkg::KIND_NAME_BYTE : uqd_pkg::KIND_VALUE_BYTE;
      end
    end
  end

  always_comb begin
    seen_upd = st.name_seen;
    if (evt_kind == uqd_pkg::KIND_PARAM_CLOSE) seen_upd = 1'b0;
    else if (evt_kind == uqd_pkg::KIND_NAME_BYTE) seen_upd = 1'b1;
  end

  always_comb begin
    if (evt_fault != uqd_pkg::FAULT_NONE) fault_fin = evt_fault;
    else if (last && !seen_upd) fault_fin = uqd_pkg::FAULT_EMPTY_NAME;
    else fault_fin = uqd_pkg::FAULT_NONE;
  end

  // Output logic
  always_comb begin
    res = '0;
    if (!st.failed) begin
      if (fault_fin != uqd_pkg::FAULT_NONE) begin
        res.fault = fault_fin;
      end else begin
        res.kind       = evt_kind;
        res.out_byte   = evt_byte;
        res.query_done = last;
      end
    end
  end

  // Next-state logic
  always_comb begin
    st_next = st;
    if (last) begin
      st_next = uqd_pkg::STATE_RESET;
    end else if (!st.failed) begin
      if (fault_fin != uqd_pkg::FAULT_NONE) begin
        st_next.failed = 1'b1;
      end else begin
        st_next.name_seen = seen_upd;
        if (!in_escape) begin
          if (evt_kind == uqd_pkg::KIND_VALUE_OPEN) begin
            st_next.mode = uqd_pkg::MODE_VALUE;
          end else if (evt_kind == uqd_pkg::KIND_PARAM_CLOSE) begin
            st_next.mode = uqd_pkg::MODE_NAME;
          end else if (c == uqd_pkg::CH_PCT) begin
            st_next.mode        = in_name ? uqd_pkg::MODE_NAME_ESC
                                          : uqd_pkg::MODE_VALUE_ESC;
            st_next.nibble_held = 1'b0;
            st_next.high_nibble = 4'd0;
          end
        end else if (!st.nibble_held) begin
          st_next.high_nibble = hv[3:0];
          st_next.nibble_held = 1'b1;
        end else begin
          st_next.high_nibble = 4'd0;
          st_next.nibble_held = 1'b0;
          st_next.mode = (st.mode == uqd_pkg::MODE_NAME_ESC) ?
                         uqd_pkg::MODE_NAME : uqd_pkg::MODE_VALUE;
        end
      end
    end
  end

endmodule

[rtl/urlencoded_query_decoder.sv]
// ----------------------------------------------------------------------------
// urlencoded_query_decoder
// Streaming decoder for form-urlencoded query strings, one result per byte.
//
//   channel   signals                          carries
//   src       src_valid, src_ready, src_data   raw byte, last-of-query flag
//   res       res_valid, res_ready, res_data   kind, decoded byte, done, fault
//
// One byte per cycle sustained while the result side is ready; an accepted byte
// is presented after passing the input register, then the result register.
// Parser state updates as a byte moves from the input to the result register.
// A stalled result holds both stages; src_ready falls only when both are full.
// rst (synchronous) empties both stages and returns the parser to name mode.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module urlencoded_query_decoder (
  input  logic          clk,
  input  logic          rst,
  input  logic          src_valid,
  output logic          src_ready,
  input  uqd_pkg::in_t  src_data,
  output logic          res_valid,
  input  logic          res_ready,
  output uqd_pkg::out_t res_data
);

  logic            s1_valid;
  uqd_pkg::in_t    s1_data;
  uqd_pkg::state_t st;
  uqd_pkg::state_t st_next;
  uqd_pkg::out_t   step_res;
  logic            advance;
  logic            res_fault;
  logic            res_clear;
  logic            st_idle;
  logic            st_escape;

  assign advance   = s1_valid && (!res_valid || res_ready);
  assign src_ready = !s1_valid || advance;

  uqd_step u_step (
    .st      (st),
    .req     (s1_data),
    .st_next (st_next),
    .res     (step_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src_ready) begin
      s1_valid <= src_valid;
    end
    if (src_ready && src_valid) begin
      s1_data <= src_data;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= uqd_pkg::STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (advance) begin
      res_data <= step_res;
    end
  end

  assign res_fault = res_valid && (res_data.fault != uqd_pkg::FAULT_NONE);
  assign res_clear = (res_data.kind == uqd_pkg::KIND_NOTHING) &&
                     (res_data.out_byte == 8'd0) && !res_data.query_done;
  assign st_idle   = (st.mode == uqd_pkg::MODE_NAME) && !st.failed &&
                     !st.name_seen && !st.nibble_held;
  assign st_escape = (st.mode == uqd_pkg::MODE_NAME_ESC) ||
                     (st.mode == uqd_pkg::MODE_VALUE_ESC);

  `ASSERT_IMPLIES(a_fault_clears_fields, res_fault, res_clear)
  `ASSERT_IMPLIES(a_done_no_fault, res_valid && res_data.query_done, !res_fault)
  `ASSERT_NEXT(a_last_resets_state, advance && s1_data.in_last, st_idle)
  `ASSERT_IMPLIES(a_nibble_in_escape, st.nibble_held, st_escape)

endmodule

[tb/urlencoded_query_decoder_tb.sv]
// ----------------------------------------------------------------------------
// urlencoded_query_decoder_tb
// Self-checking testbench for the form-urlencoded query decoder. Queries are
// streamed in one byte per request, a behavioral model of the parser predicts
// the result for each accepted byte, and every result is compared field by
// field in arrival order. Both sides idle at random, with one full-rate
// stretch and one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module urlencoded_query_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          src_valid = 1'b0;
  logic          src_ready;
  uqd_pkg::in_t  src_data = '0;
  logic          res_valid;
  logic          res_ready = 1'b0;
  uqd_pkg::out_t res_data;

  // Parser model state
  uqd_pkg::mode_t pmode;
  logic [3:0]     esc_high;
  logic           esc_half;
  logic           have_name;
  logic           in_error;

  uqd_pkg::out_t decoded_results[$];
  logic [7:0]    query_bytes[$];
  int            errors = 0;
  int            bytes_sent = 0;
  bit            src_idle_on = 1'b1;
  bit            res_idle_on = 1'b1;
  int            hold_requests = 0;
  int            hold_served = 0;
  int            hold_left = 0;
  uqd_pkg::out_t want;

  urlencoded_query_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_data  (src_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic void clear_parser();
    pmode     = uqd_pkg::MODE_NAME;
    esc_high  = 4'd0;
    esc_half  = 1'b0;
    have_name = 1'b0;
    in_error  = 1'b0;
  endfunction

  function automatic bit is_unreserved(input logic [7:0] c);
    return (c inside {[uqd_pkg::CH_0 : uqd_pkg::CH_9],
                      [uqd_pkg::CH_LOW_A : uqd_pkg::CH_LOW_Z],
                      [uqd_pkg::CH_UP_A : uqd_pkg::CH_UP_Z]}) ||
           (c inside {uqd_pkg::CH_STAR, uqd_pkg::CH_DASH, uqd_pkg::CH_DOT,
                      uqd_pkg::CH_UNDER, uqd_pkg::CH_TILDE});
  endfunction

  // Bit 4 flags a character that is not a hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c inside {[uqd_pkg::CH_0 : uqd_pkg::CH_9]})
      return {1'b0, 4'(c - uqd_pkg::CH_0)};
    if (c inside {[uqd_pkg::CH_LOW_A : uqd_pkg::CH_LOW_F]})
      return {1'b0, 4'(c - uqd_pkg::CH_LOW_A + 8'd10)};
    if (c inside {[uqd_pkg::CH_UP_A : uqd_pkg::CH_UP_F]})
      return {1'b0, 4'(c - uqd_pkg::CH_UP_A + 8'd10)};
    return 5'h10;
  endfunction

  function automatic uqd_pkg::out_t decode_byte(input uqd_pkg::in_t req);
    uqd_pkg::out_t r;
    logic [7:0]    c;
    logic [4:0]    nib;
    bit            naming;
    r = '0;
    c = req.in_byte;
    naming = (pmode == uqd_pkg::MODE_NAME);
    if (!in_error) begin
      if (pmode == uqd_pkg::MODE_NAME || pmode == uqd_pkg::MODE_VALUE) begin
        if (naming && c == uqd_pkg::CH_EQ) begin
          if (!have_name) r.fault = uqd_pkg::FAULT_EMPTY_NAME;
          else begin
            r.kind = uqd_pkg::KIND_VALUE_OPEN;
            pmode  = uqd_pkg::MODE_VALUE;
          end
        end else if (c == uqd_pkg::CH_AMP) begin
          if (!have_name) r.fault = uqd_pkg::FAULT_EMPTY_NAME;
          else begin
            r.kind    = uqd_pkg::KIND_PARAM_CLOSE;
            pmode     = uqd_pkg::MODE_NAME;
            have_name = 1'b0;
          end
        end else if (is_unreserved(c) || c == uqd_pkg::CH_PLUS) begin
          r.out_byte = (c == uqd_pkg::CH_PLUS) ? uqd_pkg::CH_SPACE : c;
          r.kind     = naming ? uqd_pkg::KIND_NAME_BYTE : uqd_pkg::KIND_VALUE_BYTE;
          if (naming) have_name = 1'b1;
        end else if (c == uqd_pkg::CH_PCT) begin
          pmode    = naming ? uqd_pkg::MODE_NAME_ESC : uqd_pkg::MODE_VALUE_ESC;
          esc_half = 1'b0;
          esc_high = 4'd0;
        end else begin
          r.fault = uqd_pkg::FAULT_DISALLOWED;
        end
      end else begin
        nib = hex_digit(c);
        if (nib[4]) begin
          r.fault = uqd_pkg::FAULT_BAD_ESCAPE;
        end else if (!esc_half) begin
          esc_high = nib[3:0];
          esc_half = 1'b1;
        end else begin
          r.out_byte = {esc_high, nib[3:0]};
          esc_half   = 1'b0;
          esc_high   = 4'd0;
          if (pmode == uqd_pkg::MODE_NAME_ESC) begin
            r.kind    = uqd_pkg::KIND_NAME_BYTE;
            have_name = 1'b1;
            pmode     = uqd_pkg::MODE_NAME;
          end else begin
            r.kind = uqd_pkg::KIND_VALUE_BYTE;
            pmode  = uqd_pkg::MODE_VALUE;
          end
        end
      end
      if (r.fault == uqd_pkg::FAULT_NONE && req.in_last) begin
        if (!have_name) r.fault = uqd_pkg::FAULT_EMPTY_NAME;
        else r.query_done = 1'b1;
      end
      if (r.fault != uqd_pkg::FAULT_NONE) begin
        r.kind       = uqd_pkg::KIND_NOTHING;
        r.out_byte   = 8'd0;
        r.query_done = 1'b0;
        in_error     = 1'b1;
      end
    end
    if (req.in_last) clear_parser();
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [7:0] b, input logic last);
    uqd_pkg::in_t req;
    req = '{in_byte: b, in_last: last};
    while (src_idle_on && $urandom_range(99) < 26) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data  <= req;
    do @(posedge clk); while (!src_ready);
    decoded_results.push_back(decode_byte(req));
    bytes_sent++;
  endtask

  task automatic send_query();
    foreach (query_bytes[i]) send_request(query_bytes[i], i == query_bytes.size() - 1);
  endtask

  task automatic send_text(input string s);
    query_bytes.delete();
    for (int i = 0; i < s.len(); i++) query_bytes.push_back(s[i]);
    send_query();
  endtask

  function automatic logic [7:0] random_plain();
    logic [7:0] marks[5];
    marks = '{uqd_pkg::CH_STAR, uqd_pkg::CH_DASH, uqd_pkg::CH_DOT,
              uqd_pkg::CH_UNDER, uqd_pkg::CH_TILDE};
    case ($urandom_range(3))
      0: return uqd_pkg::CH_0 + 8'($urandom_range(9));
      1: return uqd_pkg::CH_LOW_A + 8'($urandom_range(25));
      2: return uqd_pkg::CH_UP_A + 8'($urandom_range(25));
      default: return marks[$urandom_range(4)];
    endcase
  endfunction

  function automatic logic [7:0] random_hex();
    int v;
    v = $urandom_range(15);
    if (v < 10) return uqd_pkg::CH_0 + 8'(v);
    return ($urandom_range(1) ? uqd_pkg::CH_LOW_A : uqd_pkg::CH_UP_A) + 8'(v - 10);
  endfunction

  task automatic add_tokens(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 70) query_bytes.push_back(random_plain());
      else if (pick < 80) query_bytes.push_back(uqd_pkg::CH_PLUS);
      else begin
        query_bytes.push_back(uqd_pkg::CH_PCT);
        query_bytes.push_back(random_hex());
        query_bytes.push_back(random_hex());
      end
    end
  endtask

  // Mostly well-formed queries; about one in five gets one byte corrupted.
  task automatic build_query();
    int pos;
    query_bytes.delete();
    for (int p = 0; p < $urandom_range(1, 4); p++) begin
      if (p > 0) query_bytes.push_back(uqd_pkg::CH_AMP);
      add_tokens($urandom_range(1, 4));
      if ($urandom_range(99) < 75) begin
        query_bytes.push_back(uqd_pkg::CH_EQ);
        add_tokens($urandom_range(0, 4));
      end
    end
    if ($urandom_range(99) < 20) begin
      pos = $urandom_range(query_bytes.size() - 1);
      case ($urandom_range(3))
        0: query_bytes[pos] = 8'($urandom_range(255));
        1: query_bytes[pos] = uqd_pkg::CH_EQ;
        2: query_bytes[pos] = uqd_pkg::CH_AMP;
        default: query_bytes[pos] = uqd_pkg::CH_PCT;
      endcase
    end
  endtask

  task automatic run_queries(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      build_query();
      send_query();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  task automatic check_field(input string fname, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (decoded_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0h", $time, res_data);
          errors++;
        end else begin
          want = decoded_results.pop_front();
          check_field("kind", 8'(want.kind), 8'(res_data.kind));
          check_field("out_byte", want.out_byte, res_data.out_byte);
          check_field("query_done", 8'(want.query_done), 8'(res_data.query_done));
          check_field("fault", 8'(want.fault), 8'(res_data.fault));
        end
      end
      if (hold_served != hold_requests) begin
        hold_left = 200;
        hold_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= !res_idle_on || ($urandom_range(99) >= 26);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    send_text("%4a=+&b=%fF");  // name escape, open, plus, close, value escape, done
    send_text("=");            // empty name before '='
    send_text("&");            // empty name before '&'
    send_text("x&");           // query ends with an empty parameter
    send_text("a==");          // '=' inside a value is a disallowed byte
    send_text("%Gz");          // bad escape digit
    send_text("k%4");          // unfinished escape at end of query
    send_request(8'hff, 1'b0);
    send_request(8'h00, 1'b1);
  endtask

  task automatic test_random_queries();
    run_queries(700);
  endtask

  task automatic test_full_rate();
    src_idle_on = 1'b0;
    res_idle_on = 1'b0;
    run_queries(200);
    src_idle_on = 1'b1;
    res_idle_on = 1'b1;
  endtask

  // Hold off the result side while requests keep coming until input stalls.
  task automatic test_output_stall();
    src_idle_on = 1'b0;
    hold_requests++;
    run_queries(100);
    src_idle_on = 1'b1;
  endtask

  initial begin
    clear_parser();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_queries();
    test_full_rate();
    test_output_stall();
    // Drop valid right after the last accepted request.
    src_valid <= 1'b0;
    while (decoded_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && decoded_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
